/* hdl/ofs_pkg.sv */
// ----------------------------------------------------------------------------
// ofs_pkg
// Shared constants, codes and controller/datapath interface types of the
// octree distance field sampler.
// ----------------------------------------------------------------------------
package ofs_pkg;

    // default sizes
    localparam int DEF_NODE_COUNT  = 4096;
    localparam int DEF_DEPTH_LIMIT = 10;

    // field widths
    localparam int VAL_W   = 16;
    localparam int OFF_W   = 12;
    localparam int POS_W   = 16;
    localparam int ENTRY_W = VAL_W + OFF_W;
    localparam int CFG_IW  = 1;
    localparam int CFG_DW  = 4;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_LEVEL_LIMIT = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_FILL_MODE   = 1'b1;

    // configuration reset values
    localparam logic [3:0] LEVEL_LIMIT_RST = 4'd10;
    localparam logic [1:0] FILL_MODE_RST   = 2'd0;

    // fill modes
    localparam logic [1:0] MODE_COPY   = 2'd0;
    localparam logic [1:0] MODE_INTERP = 2'd1;
    localparam logic [1:0] MODE_LEAF   = 2'd2;

    // table read address sources
    localparam logic [1:0] SRC_ROOT = 2'd0;
    localparam logic [1:0] SRC_KID  = 2'd1;
    localparam logic [1:0] SRC_DESC = 2'd2;
    localparam logic [1:0] SRC_LEAF = 2'd3;

    // blend weight vector and corner value vector
    typedef logic [2:0][15:0] t_w3;
    typedef logic [7:0][15:0] t_v8;

    // commands from controller to datapath
    typedef struct packed {
        logic       wr;
        logic       load_in;
        logic       rd;
        logic [1:0] rd_src;
        logic       cap_base;
        logic       cap_kid;
        logic       gap;
        logic       copy;
        logic       bl_fill;
        logic       bl_fin;
        logic       bl_store;
        logic       lvl_begin;
        logic       lvl_end;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       step_inc;
        logic       res_leaf;
        logic       res_bl;
        logic       out_load;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic leaf_mode;
        logic interp;
        logic i_last;
        logic desc_real;
        logic more_lvl;
        logic q_descend;
        logic bl_busy;
        logic bl_done;
        logic out_free;
    } t_stat;

endpackage

/* hdl/ofs_ram.sv */
// ----------------------------------------------------------------------------
// ofs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ofs_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

/* hdl/ofs_blend.sv */
// ----------------------------------------------------------------------------
// ofs_blend
// Iterative trilinear blend: each corner passes through phases AB, C and V on
// a shared multiplier, eight corners summed and saturated to 16 bits.
// ----------------------------------------------------------------------------
module ofs_blend (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  ofs_pkg::t_w3    i_w,
    input  ofs_pkg::t_v8    i_v,
    output logic            o_busy,
    output logic            o_done,
    output logic [15:0]     o_result
);

    localparam logic [1:0] PH_AB = 2'd0;
    localparam logic [1:0] PH_C  = 2'd1;
    localparam logic [1:0] PH_V  = 2'd2;

    logic               r_busy;
    logic               r_done;
    logic [2:0]         r_corner;
    logic [1:0]         r_ph;
    logic [15:0]        r_p;
    logic signed [19:0] r_acc;
    logic [15:0]        r_res;
    ofs_pkg::t_w3       r_w;
    ofs_pkg::t_v8       r_v;

    logic [15:0]        w_a, w_b, w_c;
    logic signed [16:0] w_opa, w_opb;
    logic signed [33:0] w_m, w_adj;
    logic signed [19:0] w_term, w_sum;
    logic [15:0]        w_sat;

    // corner weights: bit set takes w, clear takes one minus w
    always_comb begin
        w_a = r_corner[2] ? r_w[0] : 16'(17'h08000 - {1'b0, r_w[0]});
        w_b = r_corner[1] ? r_w[1] : 16'(17'h08000 - {1'b0, r_w[1]});
        w_c = r_corner[0] ? r_w[2] : 16'(17'h08000 - {1'b0, r_w[2]});
    end

    // select multiplier operands by phase
    always_comb begin
        unique case (r_ph)
            PH_AB: begin
                w_opa = $signed({1'b0, w_a});
                w_opb = $signed({1'b0, w_b});
            end
            PH_C: begin
                w_opa = $signed({1'b0, r_p});
                w_opb = $signed({1'b0, w_c});
            end
            default: begin
                w_opa = $signed({1'b0, r_p});
                w_opb = $signed({r_v[r_corner][15], r_v[r_corner]});
            end
        endcase
    end

    // product, term truncated toward zero, running sum and saturation
    always_comb begin
        w_m    = w_opa * w_opb;
        w_adj  = w_m + (w_m[33] ? 34'sd32767 : 34'sd0);
        w_term = 20'($signed(w_adj[33:15]));
        w_sum  = r_acc + w_term;
        if (w_sum > 20'sd32767) begin
            w_sat = 16'h7FFF;
        end else if (w_sum < -20'sd32768) begin
            w_sat = 16'h8000;
        end else begin
            w_sat = w_sum[15:0];
        end
    end

    // sequence corners and phases
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy   <= 1'b1;
                r_corner <= 3'd0;
                r_ph     <= PH_AB;
                r_acc    <= '0;
                r_w      <= i_w;
                r_v      <= i_v;
            end else if (r_busy) begin
                unique case (r_ph)
                    PH_AB: begin
                        r_p  <= w_m[30:15];
                        r_ph <= PH_C;
                    end
                    PH_C: begin
                        r_p  <= w_m[30:15];
                        r_ph <= PH_V;
                    end
                    default: begin
                        r_acc <= w_sum;
                        r_ph  <= PH_AB;
                        if (r_corner == 3'd7) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                            r_res  <= w_sat;
                        end else begin
                            r_corner <= r_corner + 3'd1;
                        end
                    end
                endcase
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

/* hdl/ofs_dp.sv */
// ----------------------------------------------------------------------------
// ofs_dp
// Datapath: node table, neighborhood registers, position registers,
// configuration registers, blend unit and output register.
// ----------------------------------------------------------------------------
module ofs_dp #(
    parameter int NODE_COUNT  = ofs_pkg::DEF_NODE_COUNT,
    parameter int DEPTH_LIMIT = ofs_pkg::DEF_DEPTH_LIMIT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ofs_pkg::t_cmd               i_cmd,
    output ofs_pkg::t_stat              o_stat,
    input  logic [11:0]                 i_node_index,
    input  logic signed [15:0]          i_node_value,
    input  logic [11:0]                 i_child_offset,
    input  logic signed [15:0]          i_pos_x,
    input  logic signed [15:0]          i_pos_y,
    input  logic signed [15:0]          i_pos_z,
    input  logic                        i_cfg_valid,
    input  logic [ofs_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [ofs_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic signed [15:0]          o_distance
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int LW = $clog2(DEPTH_LIMIT + 2);
    localparam int SW = $clog2(DEPTH_LIMIT + 1);

    // configuration and output registers
    logic [3:0]  r_level_limit;
    logic [1:0]  r_fill_mode;
    logic        r_ov;
    logic [15:0] r_dist;
    logic [15:0] r_res;

    // sample state
    logic [1:0]       r_mode;
    logic [2:0][15:0] r_u;
    logic [2:0][15:0] r_n;
    logic [LW-1:0]    r_level;
    logic [SW-1:0]    r_step;
    logic [2:0]       r_i;
    logic [11:0]      r_base;

    // neighborhoods
    logic [15:0] r_cur_val  [8];
    logic [11:0] r_cur_off  [8];
    logic [7:0]  r_cur_real;
    logic [15:0] r_prev_val [8];
    logic [11:0] r_prev_off [8];
    logic [7:0]  r_prev_real;

    // table access
    logic [ofs_pkg::ENTRY_W-1:0] w_q;
    logic [11:0]                 w_q_off;
    logic [15:0]                 w_q_val;
    logic [AW-1:0]               w_rd_addr, w_wr_addr;

    // per-axis neighborhood decode
    logic [2:0][1:0]  w_pa, w_ca;
    logic [2:0][15:0] w_sh, w_fin_w;
    logic [2:0]       w_pi, w_cb, w_ch;
    logic [3:0]       w_bit;
    logic [4:0]       w_lim5;
    logic [7:0]       w_nonleaf;

    // blend
    ofs_pkg::t_w3 w_bl_w;
    ofs_pkg::t_v8 w_bl_v;
    logic         w_bl_busy, w_bl_done;
    logic [15:0]  w_bl_res;

    // reduce an index modulo the table depth
    function automatic logic [AW-1:0] f_wrap(input logic [12:0] v);
        logic [12:0] t;
        t = v;
        for (int k = 12; k >= 0; k--) begin
            if ((NODE_COUNT << k) <= 8191) begin
                if (t >= 13'(NODE_COUNT << k)) begin
                    t = t - 13'(NODE_COUNT << k);
                end
            end
        end
        return AW'(t);
    endfunction

    assign w_q_off = w_q[ofs_pkg::ENTRY_W-1:ofs_pkg::VAL_W];
    assign w_q_val = w_q[ofs_pkg::VAL_W-1:0];

    // decode parent and child picks per axis from the top bits of n
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            unique case (r_n[a][15:13])
                3'd0: begin
                    w_pa[a] = 2'b00; w_ca[a] = 2'b00; w_sh[a] = 16'd0;
                end
                3'd1, 3'd2: begin
                    w_pa[a] = 2'b00; w_ca[a] = 2'b10; w_sh[a] = 16'd0;
                end
                3'd3, 3'd4: begin
                    w_pa[a] = 2'b10; w_ca[a] = 2'b01; w_sh[a] = 16'd16384;
                end
                3'd5, 3'd6: begin
                    w_pa[a] = 2'b11; w_ca[a] = 2'b10; w_sh[a] = 16'd32768;
                end
                default: begin
                    w_pa[a] = 2'b11; w_ca[a] = 2'b11; w_sh[a] = 16'd32768;
                end
            endcase
            // final blend weight: clamp(2n - 0.5, 0, 1) in Q15, for n a Q16 fraction
            if (r_n[a] < 16'd16384) begin
                w_fin_w[a] = 16'd0;
            end else if (r_n[a] >= 16'd49152) begin
                w_fin_w[a] = 16'd32768;
            end else begin
                w_fin_w[a] = r_n[a] - 16'd16384;
            end
        end
    end

    // corner selection for the current neighborhood slot
    always_comb begin
        w_pi = {w_pa[0][r_i[2]], w_pa[1][r_i[1]], w_pa[2][r_i[0]]};
        w_cb = {w_ca[0][r_i[2]], w_ca[1][r_i[1]], w_ca[2][r_i[0]]};
        w_bit = 4'(4'd15 - 4'(r_step));
        w_ch  = {r_u[0][w_bit], r_u[1][w_bit], r_u[2][w_bit]};
        w_lim5 = (r_level_limit > 4'(DEPTH_LIMIT)) ? 5'(DEPTH_LIMIT)
                                                   : {1'b0, r_level_limit};
        for (int j = 0; j < 8; j++) begin
            w_nonleaf[j] = r_cur_real[j] && (r_cur_off[j] != 12'd0);
        end
    end

    // table read address
    always_comb begin
        unique case (i_cmd.rd_src)
            ofs_pkg::SRC_ROOT: w_rd_addr = '0;
            ofs_pkg::SRC_KID:  w_rd_addr = f_wrap({1'b0, r_base} + 13'(r_i));
            ofs_pkg::SRC_DESC: w_rd_addr = f_wrap({1'b0, r_prev_off[w_pi]} + 13'(w_cb));
            default:           w_rd_addr = f_wrap({1'b0, w_q_off} + 13'(w_ch));
        endcase
        w_wr_addr = f_wrap({1'b0, i_node_index});
    end

    ofs_ram #(
        .WIDTH (ofs_pkg::ENTRY_W),
        .DEPTH (NODE_COUNT)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr),
        .i_wr_addr (w_wr_addr),
        .i_wr_data ({i_child_offset, i_node_value}),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_q)
    );

    // blend operands: fill uses the parent neighborhood, final uses current
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            w_bl_v[j] = i_cmd.bl_fin ? r_cur_val[j] : r_prev_val[j];
        end
        for (int a = 0; a < 3; a++) begin
            w_bl_w[a] = i_cmd.bl_fin ? w_fin_w[a]
                                     : {1'b0, w_pi[2-a], w_cb[2-a], 13'd0};
        end
    end

    ofs_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.bl_fill || i_cmd.bl_fin),
        .i_w      (w_bl_w),
        .i_v      (w_bl_v),
        .o_busy   (w_bl_busy),
        .o_done   (w_bl_done),
        .o_result (w_bl_res)
    );

    // configuration and output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_limit <= ofs_pkg::LEVEL_LIMIT_RST;
            r_fill_mode   <= ofs_pkg::FILL_MODE_RST;
            r_ov          <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    ofs_pkg::CFG_LEVEL_LIMIT: r_level_limit <= i_cfg_data[3:0];
                    default:                  r_fill_mode   <= i_cfg_data[1:0];
                endcase
            end
            if (i_cmd.out_load) begin
                r_ov   <= 1'b1;
                r_dist <= r_res;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // sample working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_u[0]  <= {~i_pos_x[15], i_pos_x[14:0]};
            r_u[1]  <= {~i_pos_y[15], i_pos_y[14:0]};
            r_u[2]  <= {~i_pos_z[15], i_pos_z[14:0]};
            r_n[0]  <= {~i_pos_x[15], i_pos_x[14:0]};
            r_n[1]  <= {~i_pos_y[15], i_pos_y[14:0]};
            r_n[2]  <= {~i_pos_z[15], i_pos_z[14:0]};
            r_mode  <= (r_fill_mode == 2'd3) ? ofs_pkg::MODE_COPY : r_fill_mode;
            r_level <= LW'(1);
            r_step  <= '0;
        end
        if (i_cmd.lvl_end) begin
            for (int a = 0; a < 3; a++) begin
                r_n[a] <= {15'(r_n[a] - w_sh[a]), 1'b0};
            end
            r_level <= r_level + LW'(1);
        end
        if (i_cmd.step_inc) begin
            r_step <= r_step + SW'(1);
        end
        if (i_cmd.cnt_clr) begin
            r_i <= 3'd0;
        end else if (i_cmd.cnt_inc) begin
            r_i <= r_i + 3'd1;
        end
        if (i_cmd.cap_base) begin
            r_base <= w_q_off;
        end
        // neighborhood slot updates
        if (i_cmd.cap_kid) begin
            r_cur_val[r_i]  <= w_q_val;
            r_cur_off[r_i]  <= w_q_off;
            r_cur_real[r_i] <= 1'b1;
        end
        if (i_cmd.gap) begin
            r_cur_real[r_i] <= 1'b0;
        end
        if (i_cmd.copy) begin
            r_cur_val[r_i] <= r_prev_val[w_pi];
        end
        if (i_cmd.bl_store) begin
            r_cur_val[r_i] <= w_bl_res;
        end
        if (i_cmd.lvl_begin) begin
            r_prev_val  <= r_cur_val;
            r_prev_off  <= r_cur_off;
            r_prev_real <= r_cur_real;
        end
        // result capture
        if (i_cmd.res_leaf) begin
            r_res <= w_q_val;
        end else if (i_cmd.res_bl) begin
            r_res <= w_bl_res;
        end
    end

    // status back to the controller
    always_comb begin
        o_stat.leaf_mode = (r_mode == ofs_pkg::MODE_LEAF);
        o_stat.interp    = (r_mode == ofs_pkg::MODE_INTERP);
        o_stat.i_last    = (r_i == 3'd7);
        o_stat.desc_real = r_prev_real[w_pi] && (r_prev_off[w_pi] != 12'd0);
        o_stat.more_lvl  = (|w_nonleaf) && (5'(r_level) <= w_lim5);
        o_stat.q_descend = (5'(r_step) < 5'(DEPTH_LIMIT)) && (w_q_off != 12'd0);
        o_stat.bl_busy   = w_bl_busy;
        o_stat.bl_done   = w_bl_done;
        o_stat.out_free  = !r_ov || i_out_ready;
    end

    assign o_out_valid = r_ov;
    assign o_distance  = $signed(r_dist);

endmodule

/* hdl/ofs_ctrl.sv */
// ----------------------------------------------------------------------------
// ofs_ctrl
// Controller: sequences table reads, level descent, gap fills, blends and
// the output handoff.
// ----------------------------------------------------------------------------
module ofs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_operation,
    output logic           o_in_ready,
    input  ofs_pkg::t_stat i_stat,
    output ofs_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_L_WT  = 4'd2;
    localparam logic [3:0] S_R_WT  = 4'd3;
    localparam logic [3:0] S_K_RD  = 4'd4;
    localparam logic [3:0] S_K_WT  = 4'd5;
    localparam logic [3:0] S_LVL   = 4'd6;
    localparam logic [3:0] S_CRN   = 4'd7;
    localparam logic [3:0] S_D_WT  = 4'd8;
    localparam logic [3:0] S_F_WT  = 4'd9;
    localparam logic [3:0] S_B_WT  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!i_operation) begin
                        o_cmd.wr = 1'b1;
                    end else begin
                        o_cmd.load_in = 1'b1;
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                o_cmd.rd     = 1'b1;
                o_cmd.rd_src = ofs_pkg::SRC_ROOT;
                n_state = i_stat.leaf_mode ? S_L_WT : S_R_WT;
            end
            // nearest leaf walk: descend while the reached node has children, up to DEPTH_LIMIT steps
            S_L_WT: begin
                if (i_stat.q_descend) begin
                    o_cmd.rd       = 1'b1;
                    o_cmd.rd_src   = ofs_pkg::SRC_LEAF;
                    o_cmd.step_inc = 1'b1;
                end else begin
                    o_cmd.res_leaf = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_R_WT: begin
                o_cmd.cap_base = 1'b1;
                o_cmd.cnt_clr  = 1'b1;
                n_state = S_K_RD;
            end
            // load the root's eight children
            S_K_RD: begin
                o_cmd.rd     = 1'b1;
                o_cmd.rd_src = ofs_pkg::SRC_KID;
                n_state = S_K_WT;
            end
            S_K_WT: begin
                o_cmd.cap_kid = 1'b1;
                if (i_stat.i_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state = S_LVL;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state = S_K_RD;
                end
            end
            S_LVL: begin
                if (i_stat.more_lvl) begin
                    o_cmd.lvl_begin = 1'b1;
                    o_cmd.cnt_clr   = 1'b1;
                    n_state = S_CRN;
                end else if (!i_stat.bl_busy) begin
                    o_cmd.bl_fin = 1'b1;
                    n_state = S_B_WT;
                end
            end
            // one neighborhood slot: real child read or gap fill
            S_CRN: begin
                if (i_stat.desc_real) begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_src = ofs_pkg::SRC_DESC;
                    n_state = S_D_WT;
                end else if (i_stat.interp) begin
                    if (!i_stat.bl_busy) begin
                        o_cmd.gap     = 1'b1;
                        o_cmd.bl_fill = 1'b1;
                        n_state = S_F_WT;
                    end
                end else begin
                    o_cmd.gap  = 1'b1;
                    o_cmd.copy = 1'b1;
                    if (i_stat.i_last) begin
                        o_cmd.lvl_end = 1'b1;
                        n_state = S_LVL;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                    end
                end
            end
            S_D_WT: begin
                o_cmd.cap_kid = 1'b1;
                if (i_stat.i_last) begin
                    o_cmd.lvl_end = 1'b1;
                    n_state = S_LVL;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state = S_CRN;
                end
            end
            S_F_WT: begin
                if (i_stat.bl_done) begin
                    o_cmd.bl_store = 1'b1;
                    if (i_stat.i_last) begin
                        o_cmd.lvl_end = 1'b1;
                        n_state = S_LVL;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                        n_state = S_CRN;
                    end
                end
            end
            S_B_WT: begin
                if (i_stat.bl_done) begin
                    o_cmd.res_bl = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/octree_distance_field_sampler.sv */
// ----------------------------------------------------------------------------
// octree_distance_field_sampler
// Sparse octree signed distance sampler with trilinear neighborhood blend.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): a word with i_operation 0 writes
// one node entry (value and first child offset) and gives no result. A word
// with i_operation 1 samples at (i_pos_x, i_pos_y, i_pos_z) and gives one
// word on the output channel (o_out_valid / i_out_ready).
// Config channel (i_cfg_valid / o_cfg_ready) is always ready; index 0 is the
// level limit, index 1 the fill mode. Write it only while the block is idle.
// One sample is worked on at a time. From the accepted word to the result,
// with the output register free:
//   nearest leaf: one table read per level walked, until a node without
//                 children or DEPTH_LIMIT steps down.
//   copy fill:    the root's eight children are read, then per level each
//                 real child is read and each gap copies its parent corner;
//                 the descent stops early where only leaves remain, and a final blend gives the result.
//   interp fill:  each gap slot instead waits for its blend on the shared unit.
// The next word is accepted in the cycle after the result loads.
// Reset clears the control state and sets the level limit to 10 and the fill
// mode to copy; table contents stay undefined until written. A finished word
// waits in the output register; a stalled receiver holds the block in its
// final state until the register frees, while the next word can still be
// accepted as soon as the previous result has moved into the register.
// ----------------------------------------------------------------------------
module octree_distance_field_sampler #(
    parameter int NODE_COUNT  = ofs_pkg::DEF_NODE_COUNT,
    parameter int DEPTH_LIMIT = ofs_pkg::DEF_DEPTH_LIMIT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_operation,
    input  logic [11:0]                 i_node_index,
    input  logic signed [15:0]          i_node_value,
    input  logic [11:0]                 i_child_offset,
    input  logic signed [15:0]          i_pos_x,
    input  logic signed [15:0]          i_pos_y,
    input  logic signed [15:0]          i_pos_z,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [15:0]          o_distance,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ofs_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [ofs_pkg::CFG_DW-1:0]  i_cfg_data
);

    ofs_pkg::t_cmd  w_cmd;
    ofs_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    ofs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_ready  (o_in_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    ofs_dp #(
        .NODE_COUNT  (NODE_COUNT),
        .DEPTH_LIMIT (DEPTH_LIMIT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_node_index   (i_node_index),
        .i_node_value   (i_node_value),
        .i_child_offset (i_child_offset),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_distance     (o_distance)
    );

    // never write the table while a read is issued
    a_wr_no_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr |-> !w_cmd.rd)
        else $error("table write and read in the same cycle");

    // start a blend only on an idle blend unit
    a_bl_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.bl_fill || w_cmd.bl_fin) |-> !w_stat.bl_busy)
        else $error("blend started while busy");

    // a blend completes only after it was running
    a_bl_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.bl_done |-> $past(w_stat.bl_busy))
        else $error("blend done without a running blend");

    // a loaded result shows on the output in the next cycle
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_out_valid)
        else $error("loaded result not presented");

endmodule
